@@ sv/ffpa_pkg.sv @@
// ----------------------------------------------------------------------------
// ffpa_pkg: shared types and constants
// widths, status codes and cell interface structs of the page allocator
// ----------------------------------------------------------------------------
package ffpa_pkg;
   localparam int MaxBlocks = 32;
   localparam int AddrBits  = 48;
   localparam int PageShift = 12;
   localparam int PageBits  = AddrBits - PageShift;
   localparam int CntBits   = $clog2(MaxBlocks + 1);
   localparam int IdxBits   = $clog2(MaxBlocks);

   typedef logic [PageBits-1:0] page_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NO_SPACE  = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_FULL      = 3'd3,
      ST_REGION    = 3'd4
   } status_type;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   localparam logic CSR_START = 1'b0;
   localparam logic CSR_END   = 1'b1;

   // command broadcast to every cell
   typedef struct packed {
      logic     ins;     // insert at position pos
      logic     del;     // delete at position pos
      logic [CntBits-1:0] pos;
      page_type new_start;
      page_type new_end;
   } cell_cmd_type;

   // entry handed between neighbors
   typedef struct packed {
      page_type start_page;
      page_type end_page;
   } entry_type;
endpackage

@@ sv/ffpa_cell.sv @@
// ----------------------------------------------------------------------------
// ffpa_cell: one table slot
// holds one block, evaluates its gap and shifts on insert or delete
// ----------------------------------------------------------------------------
module ffpa_cell (
   input  logic                  clock,
   input  logic [ffpa_pkg::CntBits-1:0] my_idx,
   input  logic [ffpa_pkg::CntBits-1:0] count,
   input  ffpa_pkg::cell_cmd_type cmd,
   input  ffpa_pkg::entry_type   left,      // entry of cell i-1
   input  ffpa_pkg::entry_type   right,     // entry of cell i+1
   input  ffpa_pkg::page_type    first_page,
   input  ffpa_pkg::page_type    pages,
   input  ffpa_pkg::page_type    free_page,
   output ffpa_pkg::entry_type   entry,
   output logic                  fit,       // gap before this block fits
   output logic                  hit        // block starts at free_page
);
   import ffpa_pkg::*;

   entry_type entry_ff, entry_in;
   page_type  last;
   logic      used;

   assign used  = my_idx < count;
   assign last  = (my_idx == '0) ? first_page : left.end_page;
   assign entry = entry_ff;
   assign fit   = used && (entry_ff.start_page > last) &&
                  ((entry_ff.start_page - last) >= pages);
   assign hit   = used && (entry_ff.start_page == free_page);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins) begin
         if (my_idx == cmd.pos) begin
            entry_in.start_page = cmd.new_start;
            entry_in.end_page   = cmd.new_end;
         end else if (my_idx > cmd.pos) begin
            entry_in = left;
         end
      end else if (cmd.del && my_idx >= cmd.pos) begin
         entry_in = right;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end
endmodule

@@ sv/first_fit_page_allocator_top.sv @@
// ----------------------------------------------------------------------------
// first_fit_page_allocator_top: first-fit page allocator
// ----------------------------------------------------------------------------
// a request item is evaluated, then updates the table and registers its response
// no new item is accepted while one is evaluated; the cell row scans all gaps
//   during evaluate and shifts its entries as the response is registered
// reset: block count cleared, region registers zero (region invalid), no item
// table entries are not reset; only slots below the count are ever looked at
// ----------------------------------------------------------------------------
module first_fit_page_allocator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // req_size[47:0], free_addr[95:48]
   input  logic        req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // result_addr[47:0], status[50:48], zero
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [47:0] csr_wdata
);
   import ffpa_pkg::*;

   localparam int N = MaxBlocks;

   // page count with one carry bit
   typedef logic [PageBits:0] wpage_type;

   logic [AddrBits-1:0] rstart_ff, rend_ff;
   logic [CntBits-1:0]  count_ff, count_in;
   logic                busy_ff;           // evaluate stage holds an item
   logic                op_ff;
   page_type            pages_ff, fpage_ff;
   logic                fbad_ff;           // free addr cannot match any block
   logic                rsp_v_ff;
   logic [AddrBits-1:0] rsp_addr_ff;
   status_type          rsp_st_ff;

   page_type first_page, last_page;
   wpage_type first_page_w, req_pages_w;
   page_type req_pages, req_fpage;
   logic [AddrBits-1:0] req_size, free_addr;

   entry_type    ent [N];
   logic [N-1:0] fit, hit;
   cell_cmd_type cmd;

   assign req_size  = req_tdata[AddrBits-1:0];
   assign free_addr = req_tdata[2*AddrBits-1:AddrBits];

   // aligned region bounds in pages; the start may pass the top page
   assign first_page_w = wpage_type'(rstart_ff[AddrBits-1:PageShift])
                       + wpage_type'(|rstart_ff[PageShift-1:0]) + wpage_type'(1);
   assign first_page   = first_page_w[PageBits-1:0];
   assign last_page    = rend_ff[AddrBits-1:PageShift];

   // header page plus payload pages, rounded up; saturates to all ones,
   // which is larger than any gap
   assign req_pages_w = wpage_type'(req_size[AddrBits-1:PageShift])
                      + wpage_type'(|req_size[PageShift-1:0]) + wpage_type'(1);
   assign req_pages   = req_pages_w[PageBits] ? '1 : req_pages_w[PageBits-1:0];
   assign req_fpage   = free_addr[AddrBits-1:PageShift] - page_type'(1);

   // accept a new item only with empty evaluate stage and free output slot
   assign req_tready = !busy_ff && (!rsp_v_ff || rsp_tready);

   // cell row
   for (genvar i = 0; i < N; i++) begin : g_cell
      ffpa_cell u_cell (
         .clock      (clock),
         .my_idx     (CntBits'(i)),
         .count      (count_ff),
         .cmd        (cmd),
         .left       (ent[(i == 0) ? 0 : i-1]),
         .right      (ent[(i == N-1) ? N-1 : i+1]),
         .first_page (first_page),
         .pages      (pages_ff),
         .free_page  (fpage_ff),
         .entry      (ent[i]),
         .fit        (fit[i]),
         .hit        (hit[i])
      );
   end

   // lowest fitting cell and lowest hit cell
   logic [CntBits-1:0] fit_pos, hit_pos;
   logic               fit_any, hit_any;
   always_comb begin
      fit_pos = CntBits'(N);
      hit_pos = CntBits'(N);
      for (int i = N-1; i >= 0; i--) begin
         if (fit[i]) fit_pos = CntBits'(i);
         if (hit[i]) hit_pos = CntBits'(i);
      end
      fit_any = |fit;
      hit_any = |hit;
   end

   // tail gap and the start page of the chosen gap
   page_type tail_last, ins_start;
   logic     tail_fit, region_ok;
   logic [IdxBits-1:0] tail_idx, prev_idx;
   assign tail_idx  = IdxBits'(count_ff - CntBits'(1));
   assign prev_idx  = IdxBits'(fit_pos - CntBits'(1));
   assign tail_last = (count_ff == '0) ? first_page : ent[tail_idx].end_page;
   assign tail_fit  = (last_page > tail_last) &&
                      ((last_page - tail_last) >= pages_ff);
   assign ins_start = !fit_any ? tail_last :
                      (fit_pos == '0) ? first_page : ent[prev_idx].end_page;
   assign region_ok = wpage_type'(last_page) > first_page_w;

   status_type          st;
   logic [AddrBits-1:0] addr;
   always_comb begin
      cmd           = '0;
      cmd.new_start = ins_start;
      cmd.new_end   = ins_start + pages_ff;
      st            = ST_OK;
      addr          = '0;
      count_in      = count_ff;
      if (!region_ok) begin
         st = ST_REGION;
      end else if (op_ff == OP_ALLOC) begin
         if (count_ff >= CntBits'(N)) begin
            st = ST_FULL;
         end else if (fit_any || tail_fit) begin
            cmd.ins  = busy_ff;
            cmd.pos  = fit_any ? fit_pos : count_ff;
            addr     = {ins_start + page_type'(1), {PageShift{1'b0}}};
            count_in = count_ff + CntBits'(1);
         end else begin
            st = ST_NO_SPACE;
         end
      end else begin
         if (fbad_ff || !hit_any) begin
            st = ST_NOT_FOUND;
         end else begin
            cmd.del  = busy_ff;
            cmd.pos  = hit_pos;
            count_in = count_ff - CntBits'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rstart_ff <= '0;
         rend_ff   <= '0;
         count_ff  <= '0;
         busy_ff   <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         // output slot is always empty while an item is evaluated
         if (busy_ff)         rsp_v_ff <= 1'b1;
         else if (rsp_tready) rsp_v_ff <= 1'b0;
         busy_ff <= req_tvalid && req_tready;
         if (busy_ff) begin
            rsp_addr_ff <= addr;
            rsp_st_ff   <= st;
         end
         if (req_tvalid && req_tready) begin
            op_ff    <= req_tuser;
            pages_ff <= req_pages;
            fpage_ff <= req_fpage;
            fbad_ff  <= (|free_addr[PageShift-1:0]) ||
                        (free_addr[AddrBits-1:PageShift] == '0);
         end
         // region write empties the table
         if (csr_we)       count_ff <= '0;
         else if (busy_ff) count_ff <= count_in;
         if (csr_we) begin
            if (csr_index == CSR_START) rstart_ff <= csr_wdata;
            else                        rend_ff   <= csr_wdata;
         end
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {5'd0, rsp_st_ff, rsp_addr_ff};

   // assertions
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntBits'(N)) else $error("block count over capacity");
   a_no_ovr: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !(rsp_v_ff && !rsp_tready)) else $error("response overwritten");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      !(cmd.ins && cmd.del)) else $error("insert and delete together");
   a_busy_one: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> !busy_ff) else $error("evaluate stage held two cycles");
endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: bench for the first-fit page allocator
// drives allocate and free items through the request stream, predicts every
// response with an in-bench page table and compares it field by field
// ----------------------------------------------------------------------------
module tb;
   import ffpa_pkg::*;

   localparam int SlowLimit = 4000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;   // req_size[47:0], free_addr[95:48]
   logic        req_tuser;   // opcode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;   // result_addr[47:0], status[50:48], zero
   logic        csr_we;
   logic        csr_index;
   logic [47:0] csr_wdata;

   first_fit_page_allocator_top uut (.*);

   // allocator mirror: region registers and the sorted block table
   logic [47:0] mirror_region_start, mirror_region_end;
   page_type    mirror_start [MaxBlocks];
   page_type    mirror_end   [MaxBlocks];
   int          mirror_count;

   typedef struct packed {
      logic [47:0] addr;
      status_type  status;
   } grant_type;

   grant_type   pending_grants[$];
   logic [47:0] live_addrs[$];     // addresses handed out and not yet freed
   int          error_count;
   int          idle_count;
   int          send_idle_pct, recv_idle_pct;
   bit          hold_rsp;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // first usable page: start rounded up to a page, plus the header page
   function automatic logic [47:0] first_page();
      logic [47:0] p;
      p = {12'd0, mirror_region_start[47:12]};
      if (mirror_region_start[11:0] != 0) p = p + 1;
      return p + 1;
   endfunction

   // one step of the allocator mirror, returns the expected response
   function automatic grant_type predict_grant(op_type op, logic [47:0] size,
                                               logic [47:0] addr);
      grant_type   g;
      logic [47:0] sp, ep, last, pages, page;
      int          pos, i;
      bit          found;
      g.addr = '0;
      sp = first_page();
      ep = {12'd0, mirror_region_end[47:12]};
      if (ep <= sp) begin
         g.status = ST_REGION;
         return g;
      end
      if (op == OP_ALLOC) begin
         pages = {12'd0, size[47:12]} + 1;
         if (size[11:0] != 0) pages = pages + 1;
         if (mirror_count >= MaxBlocks) begin
            g.status = ST_FULL;
            return g;
         end
         last = sp;
         pos = mirror_count;
         found = 0;
         for (i = 0; i < mirror_count; i++) begin
            if (!found) begin
               if (mirror_start[i] > last && mirror_start[i] - last >= pages) begin
                  pos = i;
                  found = 1;
               end else begin
                  last = mirror_end[i];
               end
            end
         end
         if (!found && ep > last && ep - last >= pages) found = 1;
         if (!found) begin
            g.status = ST_NO_SPACE;
            return g;
         end
         for (i = mirror_count; i > pos; i--) begin
            mirror_start[i] = mirror_start[i-1];
            mirror_end[i]   = mirror_end[i-1];
         end
         mirror_start[pos] = last[PageBits-1:0];
         mirror_end[pos]   = last[PageBits-1:0] + pages[PageBits-1:0];
         mirror_count++;
         g.addr = (last + 1) << PageShift;
         g.status = ST_OK;
         return g;
      end
      g.status = ST_NOT_FOUND;
      if (addr[11:0] != 0 || addr < 4096) return g;
      page = {12'd0, addr[47:12]} - 1;
      for (i = 0; i < mirror_count; i++) begin
         if (g.status != ST_OK && mirror_start[i] == page[PageBits-1:0]) begin
            for (int j = i; j < mirror_count - 1; j++) begin
               mirror_start[j] = mirror_start[j+1];
               mirror_end[j]   = mirror_end[j+1];
            end
            mirror_count--;
            g.status = ST_OK;
         end
      end
      return g;
   endfunction

   // send one item, predict it at the accepting edge; valid stays up
   // so that the next item can follow back to back
   task automatic send_item(op_type op, logic [47:0] size, logic [47:0] addr);
      grant_type g;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {addr, size};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      g = predict_grant(op, size, addr);
      pending_grants.push_back(g);
      if (op == OP_ALLOC && g.status == ST_OK) live_addrs.push_back(g.addr);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register write while idle; any write empties the table
   task automatic write_region(logic [47:0] base_addr, logic [47:0] limit_addr);
      drain();
      csr_we <= 1'b1; csr_index <= CSR_START; csr_wdata <= base_addr;
      @(posedge clock);
      csr_index <= CSR_END; csr_wdata <= limit_addr;
      @(posedge clock);
      csr_we <= 1'b0;
      mirror_region_start = base_addr;
      mirror_region_end = limit_addr;
      mirror_count = 0;
      live_addrs.delete();
   endtask

   // response checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_grants.size() == 0) begin
               $display("%0t: unexpected item addr=%h status=%0d", $time,
                        rsp_tdata[47:0], rsp_tdata[50:48]);
               error_count++;
            end else begin
               grant_type g;
               g = pending_grants.pop_front();
               if (rsp_tdata[47:0] != g.addr) begin
                  $display("%0t: addr expected %h actual %h", $time, g.addr,
                           rsp_tdata[47:0]);
                  error_count++;
               end
               if (rsp_tdata[50:48] != g.status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           g.status, rsp_tdata[50:48]);
                  error_count++;
               end
            end
         end
         rsp_tready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles with no handshake on either stream and no register write
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count > SlowLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // small sizes mostly, occasionally huge ones
   function automatic logic [47:0] pick_size();
      case ($urandom_range(9))
         0: return 48'({$urandom, $urandom});
         1: return 48'd0;
         default: return 48'($urandom_range(5 * 4096));
      endcase
   endfunction

   function automatic logic [47:0] pick_free();
      int k;
      if (live_addrs.size() != 0 && $urandom_range(9) < 8) begin
         k = $urandom_range(live_addrs.size() - 1);
         pick_free = live_addrs[k];
         live_addrs.delete(k);
      end else begin
         pick_free = 48'({$urandom, $urandom});
      end
   endfunction

   task automatic test_invalid_region();
      send_item(OP_ALLOC, 48'd100, 48'd0);
      send_item(OP_FREE, 48'd0, 48'h2000);
      write_region(48'h5000, 48'h5fff);   // end page not above the first usable page
      send_item(OP_ALLOC, 48'd0, 48'd0);
   endtask

   task automatic test_directed();
      write_region(48'h1001, 48'h1_0fff);   // unaligned on both ends
      send_item(OP_ALLOC, 48'd0, 48'd0);            // header page only
      send_item(OP_ALLOC, 48'd1, 48'd0);
      send_item(OP_ALLOC, 48'd4096, 48'd0);
      send_item(OP_ALLOC, 48'hffff_ffff_ffff, 48'd0); // too large
      send_item(OP_FREE, 48'hffff_ffff_ffff, 48'h4001); // unaligned
      send_item(OP_FREE, 48'd0, 48'd0);                 // below a page
      send_item(OP_FREE, 48'd0, 48'hffff_ffff_f000);
      send_item(OP_FREE, 48'd0, pick_free());
      send_item(OP_ALLOC, 48'd0, 48'd0);                // refill first gap
      send_item(OP_ALLOC, 48'd40000, 48'd0);            // up to last gap
      // start at the top page, region invalid
      write_region(48'hffff_ffff_f001, 48'hffff_ffff_ffff);
      send_item(OP_ALLOC, 48'd0, 48'd0);
      // full table
      write_region(48'd0, 48'hffff_ffff_ffff);
      for (int i = 0; i < MaxBlocks + 1; i++) send_item(OP_ALLOC, 48'd0, 48'd0);
   endtask

   task automatic test_random(int n, int sweep);
      for (int i = 0; i < n; i++) begin
         if (i % 100 == 0) begin
            case ((sweep + i / 100) % 3)
               0: write_region(48'($urandom) & 48'hffff, 48'h40000);
               1: write_region(48'd0, 48'hffff_ffff_ffff);
               default: write_region(48'({$urandom, $urandom}),
                                     48'({$urandom, $urandom}));
            endcase
         end
         if ($urandom_range(1)) send_item(OP_ALLOC, pick_size(), 48'd0);
         else send_item(OP_FREE, pick_size(), pick_free());
      end
   endtask

   // receiver holds off a long stretch while items keep coming
   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1;
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end
         for (int i = 0; i < 20; i++) send_item(OP_ALLOC, 48'd0, 48'd0);
      join
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tuser = 1'b0;
      csr_we = 1'b0; csr_index = CSR_START; csr_wdata = '0;
      mirror_region_start = '0; mirror_region_end = '0; mirror_count = 0;
      error_count = 0; idle_count = 0; hold_rsp = 0;
      send_idle_pct = 10; recv_idle_pct = 48;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_invalid_region();
      test_directed();
      test_random(260, 0);
      send_idle_pct = 48; recv_idle_pct = 10;
      test_random(260, 1);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(260, 2);
      test_backpressure();
      drain();
      repeat (10) @(posedge clock);
      if (error_count == 0 && pending_grants.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

@@ sim.f @@
sv/ffpa_pkg.sv
sv/ffpa_cell.sv
sv/first_fit_page_allocator_top.sv
bench/tb.sv
